FILE: src/tcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text cursor controller: the cursor
// state, the configuration registers, the command codes and result items.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int MAX_RESULTS = 4;

    // Character codes with a cursor function of their own.
    localparam logic [7:0] CODE_BS    = 8'd8;
    localparam logic [7:0] CODE_TAB   = 8'd9;
    localparam logic [7:0] CODE_LF    = 8'd10;
    localparam logic [7:0] CODE_CR    = 8'd13;
    localparam logic [7:0] CODE_SPACE = 8'd32;

    // Drawing commands.
    localparam logic [1:0] CMD_GLYPH  = 2'd0;
    localparam logic [1:0] CMD_BLANK  = 2'd1;
    localparam logic [1:0] CMD_SCROLL = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_CELL_WIDTH    = 3'd0;
    localparam logic [2:0] REG_CELL_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd2;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd3;
    localparam logic [2:0] REG_COLUMNS       = 3'd4;
    localparam logic [2:0] REG_FIRST_CODE    = 3'd5;
    localparam logic [2:0] REG_CODE_COUNT    = 3'd6;

    typedef struct packed {
        logic [10:0] x;
        logic [10:0] y;
        logic [9:0]  col;
    } cursor_t;

    typedef struct packed {
        logic [5:0]  cell_width;
        logic [5:0]  cell_height;
        logic [10:0] screen_width;
        logic [10:0] screen_height;
        logic [10:0] columns_per_line;
        logic [7:0]  first_code;
        logic [8:0]  code_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0] command;
        logic [9:0] pos_x;
        logic [9:0] pos_y;
        logic [7:0] glyph_code;
        logic [9:0] scroll_lines;
        logic       last;
    } result_t;

    // All results of one character, in emission order.
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [2:0]                count;
    } batch_t;

endpackage

`default_nettype wire

FILE: src/tcc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_cfg_regs
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module tcc_cfg_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [10:0]  cfg_data,
    output tcc_pkg::cfg_t     cfg
);

    tcc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_width       <= 6'd8;
            cfg_reg.cell_height      <= 6'd8;
            cfg_reg.screen_width     <= 11'd320;
            cfg_reg.screen_height    <= 11'd320;
            cfg_reg.columns_per_line <= 11'd40;
            cfg_reg.first_code       <= 8'd32;
            cfg_reg.code_count       <= 9'd95;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcc_pkg::REG_CELL_WIDTH:    cfg_reg.cell_width       <= cfg_data[5:0];
                tcc_pkg::REG_CELL_HEIGHT:   cfg_reg.cell_height      <= cfg_data[5:0];
                tcc_pkg::REG_SCREEN_WIDTH:  cfg_reg.screen_width     <= cfg_data;
                tcc_pkg::REG_SCREEN_HEIGHT: cfg_reg.screen_height    <= cfg_data;
                tcc_pkg::REG_COLUMNS:       cfg_reg.columns_per_line <= cfg_data;
                tcc_pkg::REG_FIRST_CODE:    cfg_reg.first_code       <= cfg_data[7:0];
                tcc_pkg::REG_CODE_COUNT:    cfg_reg.code_count       <= cfg_data[8:0];
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: src/tcc_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_engine
// Combinational cursor logic: from one character and the current cursor it
// forms all drawing commands of that character and the next cursor.
// ----------------------------------------------------------------------------
module tcc_engine (
    input  wire logic [7:0]       char_code,
    input  wire tcc_pkg::cursor_t cur,
    input  wire tcc_pkg::cfg_t    cfg,
    output tcc_pkg::batch_t       batch,
    output tcc_pkg::cursor_t      cur_next
);

    typedef struct packed {
        logic [10:0] y;
        logic        has_scroll;
        logic [9:0]  scroll_lines;
    } lf_t;

    typedef struct packed {
        tcc_pkg::cursor_t cur;
        logic             has_scroll;
        logic [9:0]       scroll_lines;
        tcc_pkg::result_t draw;
    } cell_t;

    function automatic logic [9:0] sat10(input logic [10:0] v);
        return v[10] ? 10'h3FF : v[9:0];
    endfunction

    // Line feed on the y axis; x and column go to zero at the caller.
    function automatic lf_t line_feed(input logic [10:0] y, input tcc_pkg::cfg_t cf);
        lf_t         r;
        logic [11:0] ny;
        logic [12:0] lim;
        logic [12:0] ov;
        r  = '0;
        ny  = {1'b0, y} + {6'b0, cf.cell_height};
        lim = {1'b0, ny} + {7'b0, cf.cell_height};
        ov  = lim - {2'b0, cf.screen_height};
        if (lim >= {2'b0, cf.screen_height})
        begin
            // The new line lies past the bottom: scroll by the overflow and
            // pin the cursor to the last full line.
            r.has_scroll   = (lim != {2'b0, cf.screen_height});
            r.scroll_lines = (ov > 13'd1023) ? 10'h3FF : ov[9:0];
            r.y = (cf.screen_height >= {5'b0, cf.cell_height}) ?
                  (cf.screen_height - {5'b0, cf.cell_height}) : 11'd0;
        end
        else
        begin
            r.y = ny[11] ? 11'h7FF : ny[10:0];
        end
        return r;
    endfunction

    function automatic cell_t print_cell(input logic [7:0] c,
                                         input tcc_pkg::cursor_t cs,
                                         input tcc_pkg::cfg_t cf);
        cell_t       r;
        lf_t         lf;
        logic        in_font;
        logic [9:0]  font_end;
        logic [11:0] x_end;
        logic [11:0] x_adv;
        r        = '0;
        font_end = {2'b0, cf.first_code} + {1'b0, cf.code_count};
        in_font  = (c >= cf.first_code) && ({2'b0, c} < font_end);
        x_end    = {1'b0, cs.x} + {6'b0, cf.cell_width};
        lf       = line_feed(cs.y, cf);
        r.cur    = cs;
        if (in_font && (x_end > {1'b0, cf.screen_width}))
        begin
            r.cur.x        = '0;
            r.cur.col      = '0;
            r.cur.y        = lf.y;
            r.has_scroll   = lf.has_scroll;
            r.scroll_lines = lf.scroll_lines;
        end
        r.draw.command    = in_font ? tcc_pkg::CMD_GLYPH : tcc_pkg::CMD_BLANK;
        r.draw.pos_x      = sat10(r.cur.x);
        r.draw.pos_y      = sat10(r.cur.y);
        r.draw.glyph_code = in_font ? c : 8'd0;
        x_adv     = {1'b0, r.cur.x} + {6'b0, cf.cell_width};
        r.cur.x   = x_adv[11] ? 11'h7FF : x_adv[10:0];
        r.cur.col = (r.cur.col == 10'h3FF) ? r.cur.col : r.cur.col + 10'd1;
        return r;
    endfunction

    function automatic tcc_pkg::result_t scroll_result(input logic [9:0] lines);
        tcc_pkg::result_t r;
        r              = '0;
        r.command      = tcc_pkg::CMD_SCROLL;
        r.scroll_lines = lines;
        return r;
    endfunction

    logic        is_tab;
    cell_t       p1;
    cell_t       p2;
    lf_t         lf_now;
    logic [10:0] bs_col;
    logic [9:0]  bs_col_sat;
    logic [15:0] bs_prod;
    logic [2:0]  n;

    assign is_tab = (char_code == tcc_pkg::CODE_TAB);
    // A tab is one space, and a second one when the column is left odd.
    assign p1     = print_cell(is_tab ? tcc_pkg::CODE_SPACE : char_code, cur, cfg);
    assign p2     = print_cell(tcc_pkg::CODE_SPACE, p1.cur, cfg);
    assign lf_now = line_feed(cur.y, cfg);

    assign bs_col     = (cfg.columns_per_line != 11'd0) ?
                        (cfg.columns_per_line - 11'd1) : 11'd0;
    assign bs_col_sat = bs_col[10] ? 10'h3FF : bs_col[9:0];
    assign bs_prod    = {6'b0, bs_col_sat} * {10'b0, cfg.cell_width};

    always_comb
    begin
        batch    = '0;
        cur_next = cur;
        n        = 3'd0;
        unique case (char_code)
            tcc_pkg::CODE_BS:
            begin
                if (cur.x < {5'b0, cfg.cell_width})
                begin
                    // Left edge: last column of the line above.
                    cur_next.y   = (cur.y > {5'b0, cfg.cell_height}) ?
                                   (cur.y - {5'b0, cfg.cell_height}) : 11'd0;
                    cur_next.col = bs_col_sat;
                    cur_next.x   = (bs_prod > 16'd2047) ? 11'h7FF : bs_prod[10:0];
                end
                else
                begin
                    cur_next.x   = cur.x - {5'b0, cfg.cell_width};
                    cur_next.col = (cur.col != 10'd0) ? (cur.col - 10'd1) : 10'd0;
                end
            end
            tcc_pkg::CODE_CR:
            begin
                cur_next.x   = '0;
                cur_next.col = '0;
            end
            tcc_pkg::CODE_LF:
            begin
                cur_next.x   = '0;
                cur_next.col = '0;
                cur_next.y   = lf_now.y;
                if (lf_now.has_scroll)
                begin
                    batch.res[0] = scroll_result(lf_now.scroll_lines);
                    n            = 3'd1;
                end
            end
            default:
            begin
                if (p1.has_scroll)
                begin
                    batch.res[n[1:0]] = scroll_result(p1.scroll_lines);
                    n                 = n + 3'd1;
                end
                batch.res[n[1:0]] = p1.draw;
                n                 = n + 3'd1;
                cur_next          = p1.cur;
                if (is_tab && p1.cur.col[0])
                begin
                    if (p2.has_scroll)
                    begin
                        batch.res[n[1:0]] = scroll_result(p2.scroll_lines);
                        n                 = n + 3'd1;
                    end
                    batch.res[n[1:0]] = p2.draw;
                    n                 = n + 3'd1;
                    cur_next          = p2.cur;
                end
            end
        endcase
        for (int i = 0; i < tcc_pkg::MAX_RESULTS; i++)
        begin
            batch.res[i].last = (3'(i) == (n - 3'd1));
        end
        batch.count = n;
    end

endmodule

`default_nettype wire

FILE: src/tcc_out_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_out_buffer
// Result register: holds the commands of one character and hands them out
// one per cycle while ready holds; it is free in the cycle the last is taken.
// ----------------------------------------------------------------------------
module tcc_out_buffer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tcc_pkg::batch_t batch,
    input  wire logic            load,
    output logic                 free,
    output tcc_pkg::result_t     result,
    output logic                 valid,
    input  wire logic            ready
);

    tcc_pkg::result_t [tcc_pkg::MAX_RESULTS-1:0] res_reg;
    logic [2:0] count_reg;
    logic [1:0] idx_reg;
    logic       take;
    logic       take_last;

    assign valid     = (count_reg != 3'd0);
    assign take      = valid && ready;
    assign take_last = take && (({1'b0, idx_reg} + 3'd1) == count_reg);
    assign free      = !valid || take_last;
    assign result    = res_reg[idx_reg];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= batch.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            count_reg <= batch.count;
            idx_reg   <= 2'd0;
        end
        else if (take_last)
        begin
            count_reg <= 3'd0;
            idx_reg   <= 2'd0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

`default_nettype wire

FILE: src/text_cursor_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_cursor_controller_top
// Character-cell cursor controller: takes character codes and emits glyph,
// blank-cell and scroll commands for a pixel text display.
// ----------------------------------------------------------------------------
// A request's first command passes the input register, the cursor logic and
// then the result register, which takes it only once that register is free.
// Throughput: one character per cycle with m_tready high while each yields
// at most one command; more commands hold the result register until taken.
// Reset: asynchronous, active low; cursor goes to the top left corner and the
// configuration registers return to their default values.
// ----------------------------------------------------------------------------
module text_cursor_controller_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Configuration write port.
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [10:0]  cfg_data,
    // Character input.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] char_code
    // Command output.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata,   // command, pos_x, pos_y, glyph_code,
                                         // scroll_lines (lowest bit up)
    output logic              m_tlast
);

    tcc_pkg::cfg_t    cfg;
    tcc_pkg::cursor_t cur_reg;
    tcc_pkg::cursor_t cur_next;
    tcc_pkg::batch_t  batch;
    tcc_pkg::result_t result;
    logic [7:0]       char_reg;
    logic             in_valid_reg;
    logic             buf_free;
    logic             adv;

    tcc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcc_engine u_engine (
        .char_code (char_reg),
        .cur       (cur_reg),
        .cfg       (cfg),
        .batch     (batch),
        .cur_next  (cur_next)
    );

    tcc_out_buffer u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .batch  (batch),
        .load   (adv),
        .free   (buf_free),
        .result (result),
        .valid  (m_tvalid),
        .ready  (m_tready)
    );

    // The held character moves on as soon as the result register is free.
    assign adv      = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cur_reg      <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (adv)
            begin
                cur_reg <= cur_next;
            end
        end
    end

    assign m_tdata = {result.scroll_lines, result.glyph_code, result.pos_y,
                      result.pos_x, result.command};
    assign m_tlast = result.last;

    a_idle_out_advances: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !m_tvalid |-> adv)
        else $error("held character did not advance into an empty result register");

    a_cursor_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(cur_reg))
        else $error("cursor changed without a character advancing");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but request not accepted");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text cursor controller. Character codes are
// streamed in with random sender gaps and receiver stalls, a cursor model in
// the bench predicts the glyph, blank-cell and scroll commands of each
// accepted request, and every command that comes out is compared field by
// field with the oldest prediction. The font and screen settings are changed
// between phases, the extreme and out-of-range values among them.
// ----------------------------------------------------------------------------
module testbench;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = tcc_pkg::REG_CELL_WIDTH;
    logic [10:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // Cursor model state and its copy of the settings.
    tcc_pkg::cursor_t pen;
    tcc_pkg::cfg_t    font_cfg;
    tcc_pkg::result_t char_cmds[$];
    tcc_pkg::result_t expected_cmds[$];

    logic [7:0]  pending_chars[$];
    logic        char_accepted = 1'b0;
    int          chars_queued = 0;
    int          chars_taken = 0;
    int          errors = 0;

    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          ctrl_pct = 35;
    int          gen_first = 32;
    int          gen_count = 95;

    text_cursor_controller_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [9:0] clip_field(int v);
        return (v > 1023) ? 10'd1023 : 10'(v);
    endfunction

    function automatic logic [10:0] clip_pixel(int v);
        return (v > 2047) ? 11'd2047 : 11'(v);
    endfunction

    function automatic void add_command(logic [1:0] cmd, int x, int y, int g, int s);
        tcc_pkg::result_t r;
        if (char_cmds.size() >= tcc_pkg::MAX_RESULTS)
        begin
            return;
        end
        r.command      = cmd;
        r.pos_x        = clip_field(x);
        r.pos_y        = clip_field(y);
        r.glyph_code   = 8'(g);
        r.scroll_lines = clip_field(s);
        r.last         = 1'b0;
        char_cmds.push_back(r);
    endfunction

    function automatic void feed_line();
        int ny;
        int ov;
        ny = int'(pen.y) + int'(font_cfg.cell_height);
        ov = ny + int'(font_cfg.cell_height) - int'(font_cfg.screen_height);
        // An overflow of exactly zero moves the line without any scroll.
        if (ov >= 0)
        begin
            if (ov > 0)
            begin
                add_command(tcc_pkg::CMD_SCROLL, 0, 0, 0, ov);
            end
            ny -= ov;
            if (ny < 0)
            begin
                ny = 0;
            end
        end
        pen.x   = '0;
        pen.col = '0;
        pen.y   = clip_pixel(ny);
    endfunction

    function automatic void print_cell(int c);
        logic in_font;
        in_font = (c >= int'(font_cfg.first_code)) &&
                  (c < int'(font_cfg.first_code) + int'(font_cfg.code_count));
        if (in_font)
        begin
            if (int'(pen.x) + int'(font_cfg.cell_width) > int'(font_cfg.screen_width))
            begin
                feed_line();
            end
            add_command(tcc_pkg::CMD_GLYPH, pen.x, pen.y, c, 0);
        end
        else
        begin
            add_command(tcc_pkg::CMD_BLANK, pen.x, pen.y, 0, 0);
        end
        pen.x   = clip_pixel(int'(pen.x) + int'(font_cfg.cell_width));
        pen.col = (pen.col == 10'd1023) ? pen.col : pen.col + 10'd1;
    endfunction

    function automatic void predict_commands(logic [7:0] c);
        int               col;
        tcc_pkg::result_t tail;
        char_cmds.delete();
        case (c)
            tcc_pkg::CODE_BS:
            begin
                if (pen.x < font_cfg.cell_width)
                begin
                    col = (font_cfg.columns_per_line != 0) ?
                          int'(font_cfg.columns_per_line) - 1 : 0;
                    pen.y   = (pen.y > font_cfg.cell_height) ? pen.y - font_cfg.cell_height : '0;
                    pen.col = (col > 1023) ? 10'd1023 : 10'(col);
                    pen.x   = clip_pixel(int'(pen.col) * int'(font_cfg.cell_width));
                end
                else
                begin
                    pen.x   = pen.x - font_cfg.cell_width;
                    pen.col = (pen.col != 0) ? pen.col - 10'd1 : '0;
                end
            end
            tcc_pkg::CODE_CR:
            begin
                pen.x   = '0;
                pen.col = '0;
            end
            tcc_pkg::CODE_LF:
            begin
                feed_line();
            end
            tcc_pkg::CODE_TAB:
            begin
                print_cell(tcc_pkg::CODE_SPACE);
                if (pen.col[0])
                begin
                    print_cell(tcc_pkg::CODE_SPACE);
                end
            end
            default:
            begin
                print_cell(c);
            end
        endcase
        if (char_cmds.size() > 0)
        begin
            tail = char_cmds.pop_back();
            tail.last = 1'b1;
            char_cmds.push_back(tail);
        end
        foreach (char_cmds[i])
        begin
            expected_cmds.push_back(char_cmds[i]);
        end
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [10:0] value);
        case (idx)
            tcc_pkg::REG_CELL_WIDTH:    font_cfg.cell_width       = value[5:0];
            tcc_pkg::REG_CELL_HEIGHT:   font_cfg.cell_height      = value[5:0];
            tcc_pkg::REG_SCREEN_WIDTH:  font_cfg.screen_width     = value;
            tcc_pkg::REG_SCREEN_HEIGHT: font_cfg.screen_height    = value;
            tcc_pkg::REG_COLUMNS:       font_cfg.columns_per_line = value;
            tcc_pkg::REG_FIRST_CODE:    font_cfg.first_code       = value[7:0];
            tcc_pkg::REG_CODE_COUNT:    font_cfg.code_count       = value[8:0];
            default:                    ;
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Monitor: the model advances on each accepted request and each accepted
    // command is checked against the oldest prediction.
    always @(posedge clk)
    begin
        tcc_pkg::result_t got;
        tcc_pkg::result_t want;
        if (!rst_n)
        begin
            pen = '0;
            font_cfg = '{cell_width: 6'd8, cell_height: 6'd8, screen_width: 11'd320,
                         screen_height: 11'd320, columns_per_line: 11'd40,
                         first_code: 8'd32, code_count: 9'd95};
            char_accepted <= 1'b0;
        end
        else
        begin
            char_accepted <= s_tvalid && s_tready;
            if (cfg_we)
            begin
                apply_register(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready)
            begin
                predict_commands(s_tdata);
                chars_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                got.command      = m_tdata[1:0];
                got.pos_x        = m_tdata[11:2];
                got.pos_y        = m_tdata[21:12];
                got.glyph_code   = m_tdata[29:22];
                got.scroll_lines = m_tdata[39:30];
                got.last         = m_tlast;
                if (expected_cmds.size() == 0)
                begin
                    $display("%0t: command with none expected, expected nothing, actual %h last %b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    check_field("command", want.command, got.command);
                    check_field("pos_x", want.pos_x, got.pos_x);
                    check_field("pos_y", want.pos_y, got.pos_y);
                    check_field("glyph_code", want.glyph_code, got.glyph_code);
                    check_field("scroll_lines", want.scroll_lines, got.scroll_lines);
                    check_field("last", want.last, got.last);
                end
            end
        end
    end

    // Driver: a new request is offered once the current one has been taken.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || char_accepted)
        begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                s_tdata  <= pending_chars.pop_front();
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic send(logic [7:0] c);
        pending_chars.push_back(c);
        chars_queued++;
    endtask

    // Carriage return and backspace give no command, so drain waits on past the
    // empty queues to let the last of them settle before the settings change.
    task automatic drain();
        while (chars_taken != chars_queued || expected_cmds.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_settings(int cw, int ch, int sw, int sh, int cpl, int fc, int cnt);
        logic [10:0] vals [7];
        logic [2:0]  regs [7];
        vals = '{11'(cw), 11'(ch), 11'(sw), 11'(sh), 11'(cpl), 11'(fc), 11'(cnt)};
        regs = '{tcc_pkg::REG_CELL_WIDTH, tcc_pkg::REG_CELL_HEIGHT,
                 tcc_pkg::REG_SCREEN_WIDTH, tcc_pkg::REG_SCREEN_HEIGHT,
                 tcc_pkg::REG_COLUMNS, tcc_pkg::REG_FIRST_CODE,
                 tcc_pkg::REG_CODE_COUNT};
        gen_first = fc & 255;
        gen_count = cnt & 511;
        for (int i = 0; i < 7; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Small values are favored so that wraps and scrolls come often.
    function automatic int pick_value(int lo, int hi, int full);
        case ($urandom_range(9))
            0:       return lo;
            1:       return hi;
            2:       return $urandom_range(full);
            3, 4, 5: return $urandom_range(lo + (hi - lo) / 16, lo);
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    task automatic random_settings();
        int cw, ch, sw, sh, cpl, fc, cnt;
        cw  = pick_value(1, 32, 63);
        ch  = pick_value(1, 32, 63);
        sw  = pick_value(1, 1024, 2047);
        sh  = pick_value(1, 1024, 2047);
        cpl = pick_value(1, 1024, 2047);
        fc  = pick_value(0, 255, 255);
        cnt = pick_value(0, 256, 511);
        write_settings(cw, ch, sw, sh, cpl, fc, cnt);
    endtask

    // Mostly text in the font range mixed with cursor controls, plus noise.
    function automatic logic [7:0] next_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < ctrl_pct)
        begin
            case ($urandom_range(3))
                0:       return tcc_pkg::CODE_BS;
                1:       return tcc_pkg::CODE_TAB;
                2:       return tcc_pkg::CODE_LF;
                default: return tcc_pkg::CODE_CR;
            endcase
        end
        roll = $urandom_range(9);
        if (roll < 6 && gen_count > 0)
        begin
            return 8'(gen_first + $urandom_range(gen_count - 1));
        end
        if (roll < 9)
        begin
            return 8'($urandom_range(255));
        end
        return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    endfunction

    task automatic run_random(int count);
        repeat (count) send(next_char());
        drain();
    endtask

    initial
    begin
        logic [7:0] opening [16];
        logic [7:0] small_screen [8];
        opening = '{8'd65, 8'd126, 8'd127, 8'd0, 8'd255, 8'd31, tcc_pkg::CODE_SPACE,
                    tcc_pkg::CODE_BS, tcc_pkg::CODE_CR, tcc_pkg::CODE_BS, 8'd65, 8'd66,
                    tcc_pkg::CODE_TAB, tcc_pkg::CODE_TAB, tcc_pkg::CODE_LF,
                    tcc_pkg::CODE_BS};
        // With the whole code range in the font, the controls must still act
        // as controls; the two line feeds give a zero and a real overflow.
        small_screen = '{tcc_pkg::CODE_CR, tcc_pkg::CODE_BS, tcc_pkg::CODE_CR,
                         tcc_pkg::CODE_LF, tcc_pkg::CODE_LF, tcc_pkg::CODE_TAB, 8'd65,
                         tcc_pkg::CODE_TAB};
        sender_idle_pct    = 34;
        receiver_stall_pct = 52;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (opening[i])
        begin
            send(opening[i]);
        end
        drain();
        write_settings(8, 8, 24, 16, 3, 0, 256);
        foreach (small_screen[i])
        begin
            send(small_screen[i]);
        end
        drain();

        random_settings();
        run_random(41);
        // Cells wider and taller than the screen: every glyph wraps, a tab can
        // give four commands, and the line position would fall below zero and is held at zero.
        write_settings(32, 32, 16, 16, 0, 0, 256);
        run_random(41);

        sender_idle_pct    = 52;
        receiver_stall_pct = 34;
        write_settings(1, 1, 1, 1, 1, 0, 0);
        run_random(41);
        write_settings(32, 32, 1024, 1024, 1024, 255, 256);
        run_random(41);
        // Few controls so the cursor runs far enough right to saturate.
        ctrl_pct = 4;
        write_settings(63, 63, 2047, 2047, 2047, 255, 511);
        run_random(41);
        ctrl_pct = 35;

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        random_settings();
        run_random(41);
        random_settings();
        run_random(41);

        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
